@@ rtl/level_bar_graph_hysteresis_unit_defines.svh @@
// Assertion macros for the level bar graph unit.
`ifndef LEVEL_BAR_GRAPH_HYSTERESIS_UNIT_DEFINES_SVH
`define LEVEL_BAR_GRAPH_HYSTERESIS_UNIT_DEFINES_SVH

`ifndef SYNTH
`define LBGH_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("lbgh assertion failed");
`define LBGH_ASSERT_NR(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("lbgh assertion failed");
`else
`define LBGH_ASSERT(name, clk, rst_n, prop)
`define LBGH_ASSERT_NR(name, clk, prop)
`endif

`endif

@@ rtl/lbgh_pkg.sv @@
package lbgh_pkg;

  localparam int unsigned LevelW = 8;
  localparam int unsigned BarsW  = 4;
  localparam int unsigned HystW  = 5;
  localparam int unsigned SumW   = LevelW + 2;

  localparam int unsigned StepSize = 25;
  localparam int unsigned TopBars  = 10;

  localparam logic [LevelW-1:0] BadLimitRst = 8'd251;
  localparam logic [HystW-1:0]  HystRst     = 5'd1;

  typedef enum logic {
    RegBadDataLimit = 1'b0,
    RegHysteresis   = 1'b1
  } reg_idx_e;

endpackage

@@ rtl/lbgh_eval.sv @@
module lbgh_eval (
  input  logic [lbgh_pkg::BarsW-1:0]  bars_i,
  input  logic [lbgh_pkg::LevelW-1:0] avg_i,
  input  logic [lbgh_pkg::HystW-1:0]  hyst_i,
  output logic [lbgh_pkg::BarsW-1:0]  bars_o
);

  logic [lbgh_pkg::BarsW-1:0] band;
  logic [lbgh_pkg::BarsW-1:0] desc_bars;
  logic                       desc_hit;
  logic [lbgh_pkg::LevelW:0]  avg_ext;
  logic [lbgh_pkg::LevelW:0]  avg_hyst;

  assign avg_ext  = {1'b0, avg_i};
  assign avg_hyst = avg_ext + (lbgh_pkg::LevelW+1)'(hyst_i);

  // band the average falls into, top band open-ended
  always_comb begin
    band = lbgh_pkg::BarsW'(lbgh_pkg::TopBars);
    for (int k = lbgh_pkg::TopBars - 1; k >= 0; k--) begin
      if (avg_ext < (lbgh_pkg::LevelW+1)'(lbgh_pkg::StepSize * (k + 1))) begin
        band = lbgh_pkg::BarsW'(k);
      end
    end
  end

  // lowest bar count whose off threshold the average has dropped to
  always_comb begin
    desc_hit  = 1'b0;
    desc_bars = '0;
    for (int k = 0; k < lbgh_pkg::TopBars; k++) begin
      if (!desc_hit && (bars_i > lbgh_pkg::BarsW'(k)) &&
          (avg_hyst <= (lbgh_pkg::LevelW+1)'(lbgh_pkg::StepSize * (k + 1)))) begin
        desc_hit  = 1'b1;
        desc_bars = lbgh_pkg::BarsW'(k);
      end
    end
  end

  always_comb begin
    if (bars_i <= band) begin
      bars_o = band;
    end else if (desc_hit) begin
      bars_o = desc_bars;
    end else begin
      bars_o = bars_i;
    end
  end

endmodule

@@ rtl/level_bar_graph_hysteresis_unit.sv @@
// Channel  Handshake                   Payload
// -------  --------------------------  -----------------------------------------
// in       in_valid_i / in_stall_o     raw_level_i, timed_out_i
// out      out_valid_o / out_stall_i   bar_count_o, sensor_error_o, average_level_o
// cfg      cfg_we_i                    cfg_index_i, cfg_wdata_i
//
// One item per cycle sustained while out_stall_i is low; an item passes from the
// input register to the result register, and the window sum, average and bar
// evaluation run in one pass between the two. Reset is asynchronous and active
// low and clears control, window and config state but not the payload registers.
// A stalled result holds the input register; a new item is taken while it is empty.
`include "level_bar_graph_hysteresis_unit_defines.svh"

module level_bar_graph_hysteresis_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [lbgh_pkg::LevelW-1:0]   raw_level_i,
  input  logic                          timed_out_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [lbgh_pkg::BarsW-1:0]    bar_count_o,
  output logic                          sensor_error_o,
  output logic [lbgh_pkg::LevelW-1:0]   average_level_o,
  input  logic                          cfg_we_i,
  input  logic                          cfg_index_i,
  input  logic [lbgh_pkg::LevelW-1:0]   cfg_wdata_i
);

  logic                        in_valid_q;
  logic [lbgh_pkg::LevelW-1:0] raw_q;
  logic                        timed_out_q;
  logic                        out_valid_q;
  logic [lbgh_pkg::BarsW-1:0]  out_bars_q;
  logic                        out_err_q;
  logic [lbgh_pkg::LevelW-1:0] out_avg_q;

  logic [lbgh_pkg::LevelW-1:0] bad_limit_q;
  logic [lbgh_pkg::HystW-1:0]  hyst_q;

  logic                        first_q;
  logic [lbgh_pkg::LevelW-1:0] win_q [4];
  logic [lbgh_pkg::LevelW-1:0] win_d [4];
  logic [1:0]                  slot_q;
  logic [lbgh_pkg::LevelW-1:0] last_avg_q;
  logic [lbgh_pkg::BarsW-1:0]  bars_q;

  logic                        out_free;
  logic                        load;
  logic                        in_accept;
  logic                        err;
  logic [lbgh_pkg::LevelW-1:0] sample;
  logic [lbgh_pkg::SumW-1:0]   sum;
  logic [lbgh_pkg::LevelW-1:0] avg;
  logic [lbgh_pkg::BarsW-1:0]  bars_base;
  logic [lbgh_pkg::BarsW-1:0]  bars_eval;
  logic [lbgh_pkg::BarsW-1:0]  bars_d;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign load       = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign in_accept  = in_valid_i && !in_stall_o;

  assign err    = timed_out_q || (raw_q >= bad_limit_q);
  assign sample = err ? '0 : raw_q;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (first_q || (slot_q == 2'(i))) begin
        win_d[i] = sample;
      end else begin
        win_d[i] = win_q[i];
      end
    end
  end

  assign sum = lbgh_pkg::SumW'(win_d[0]) + lbgh_pkg::SumW'(win_d[1]) +
               lbgh_pkg::SumW'(win_d[2]) + lbgh_pkg::SumW'(win_d[3]);
  assign avg = sum[lbgh_pkg::SumW-1:2];

  assign bars_base = err ? '0 : bars_q;

  lbgh_eval u_eval (
    .bars_i (bars_base),
    .avg_i  (avg),
    .hyst_i (hyst_q),
    .bars_o (bars_eval)
  );

  assign bars_d = (avg != last_avg_q) ? bars_eval : bars_base;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bad_limit_q <= lbgh_pkg::BadLimitRst;
      hyst_q      <= lbgh_pkg::HystRst;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        lbgh_pkg::RegBadDataLimit: bad_limit_q <= cfg_wdata_i;
        lbgh_pkg::RegHysteresis:   hyst_q <= cfg_wdata_i[lbgh_pkg::HystW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        in_valid_q <= 1'b1;
      end else if (load) begin
        in_valid_q <= 1'b0;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q    <= 1'b1;
      slot_q     <= '0;
      last_avg_q <= '0;
      bars_q     <= '0;
      for (int i = 0; i < 4; i++) begin
        win_q[i] <= '0;
      end
    end else if (load) begin
      first_q    <= 1'b0;
      slot_q     <= slot_q + 2'd1;
      last_avg_q <= avg;
      bars_q     <= bars_d;
      for (int i = 0; i < 4; i++) begin
        win_q[i] <= win_d[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      raw_q       <= raw_level_i;
      timed_out_q <= timed_out_i;
    end
    if (load) begin
      out_bars_q <= bars_d;
      out_err_q  <= err;
      out_avg_q  <= avg;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign bar_count_o     = out_bars_q;
  assign sensor_error_o  = out_err_q;
  assign average_level_o = out_avg_q;

  `LBGH_ASSERT(a_bars_range, clk_i, rst_ni, bars_q <= lbgh_pkg::BarsW'(lbgh_pkg::TopBars))
  `LBGH_ASSERT(a_bars_hold, clk_i, rst_ni, (load && !err && (avg == last_avg_q)) |=> (bars_q == $past(bars_q)))
  `LBGH_ASSERT_NR(a_rst_idle, clk_i, !rst_ni |-> (!out_valid_o && !in_stall_o))

endmodule
